// ===== hw/rtl/sitrd_pkg.sv =====
// Shared types and constants for the signed integer to radix digits unit.
// Used by the register block, the shared divider and the top level.
`default_nettype none

package sitrd_pkg;

   localparam int MAX_SYMBOLS     = 16;
   localparam int MAX_DIGITS      = 32;
   localparam int VALUE_WIDTH     = 32;
   localparam int DIGIT_WIDTH     = $clog2(MAX_SYMBOLS);
   localparam int BASE_WIDTH      = DIGIT_WIDTH + 1;
   localparam int DEPTH_WIDTH     = $clog2(MAX_DIGITS) + 1;
   localparam int STEPS_PER_CYCLE = 8;
   localparam int DIV_CYCLES      = VALUE_WIDTH / STEPS_PER_CYCLE;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_CYCLES);

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_ADDR_WIDTH  = 5;

   localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
   localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

   localparam logic [7:0]            CHAR_MINUS = 8'h2D;
   localparam logic [7:0]            CHAR_PLUS  = 8'h2B;
   localparam logic [7:0]            CHAR_NUL   = 8'h00;
   localparam logic [BASE_WIDTH-1:0] MIN_BASE   = BASE_WIDTH'(2);

   typedef struct packed {
      logic [BASE_WIDTH-1:0]             base_size;
      logic [MAX_SYMBOLS-1:0][7:0]       symbols;
      logic                              valid;
   } cfg_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [DIGIT_WIDTH-1:0] remainder;
   } div_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sitrd_csr.sv =====
// Configuration registers (radix and symbol table) behind an APB-style port,
// plus the configuration validity check. Depends on sitrd_pkg.
`default_nettype none

module sitrd_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [sitrd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                        csr_pready,
   output sitrd_pkg::cfg_type                          cfg
);

   logic [sitrd_pkg::BASE_WIDTH-1:0] base_size_ff;
   logic [sitrd_pkg::BASE_WIDTH-1:0] base_size_in;
   logic [63:0]                      symbols_low_ff;
   logic [63:0]                      symbols_low_in;
   logic [63:0]                      symbols_high_ff;
   logic [63:0]                      symbols_high_in;
   logic                             write_en;
   logic [1:0]                       reg_index;
   logic [sitrd_pkg::MAX_SYMBOLS-1:0][7:0] symbols;
   logic                             bad_symbol;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:3];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign symbols    = {symbols_high_ff, symbols_low_ff};

   always_comb begin
      base_size_in    = base_size_ff;
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      if (write_en) begin
         case (reg_index)
            sitrd_pkg::REG_BASE_SIZE: begin
               base_size_in = csr_pwdata[sitrd_pkg::BASE_WIDTH-1:0];
            end
            sitrd_pkg::REG_SYMBOLS_LOW: begin
               symbols_low_in = csr_pwdata;
            end
            sitrd_pkg::REG_SYMBOLS_HIGH: begin
               symbols_high_in = csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff    <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else begin
         base_size_ff    <= base_size_in;
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
      end
   end

   always_comb begin
      case (reg_index)
         sitrd_pkg::REG_BASE_SIZE:    csr_prdata = 64'(base_size_ff);
         sitrd_pkg::REG_SYMBOLS_LOW:  csr_prdata = symbols_low_ff;
         sitrd_pkg::REG_SYMBOLS_HIGH: csr_prdata = symbols_high_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // Every symbol in use must be other than minus, plus and NUL and distinct from the
   // others; the pairwise compares are independent and reduce with one OR.
   always_comb begin
      bad_symbol = 1'b0;
      for (int i = 0; i < sitrd_pkg::MAX_SYMBOLS; i++) begin
         if (sitrd_pkg::BASE_WIDTH'(i) < base_size_ff) begin
            if (symbols[i] == sitrd_pkg::CHAR_MINUS || symbols[i] == sitrd_pkg::CHAR_PLUS ||
                symbols[i] == sitrd_pkg::CHAR_NUL) begin
               bad_symbol = 1'b1;
            end
            for (int j = i + 1; j < sitrd_pkg::MAX_SYMBOLS; j++) begin
               if (sitrd_pkg::BASE_WIDTH'(j) < base_size_ff && symbols[j] == symbols[i]) begin
                  bad_symbol = 1'b1;
               end
            end
         end
      end
   end

   assign cfg.base_size = base_size_ff;
   assign cfg.symbols   = symbols;
   assign cfg.valid     = (base_size_ff >= sitrd_pkg::MIN_BASE) &&
                          (base_size_ff <= sitrd_pkg::BASE_WIDTH'(sitrd_pkg::MAX_SYMBOLS)) &&
                          !bad_symbol;

endmodule

`default_nettype wire

// ===== hw/rtl/sitrd_div.sv =====
// Shared restoring divider: 32-bit dividend by a radix of at most 16,
// several quotient bits per cycle. Depends on sitrd_pkg.
`default_nettype none

module sitrd_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [sitrd_pkg::VALUE_WIDTH-1:0]   dividend,
   input  wire logic [sitrd_pkg::BASE_WIDTH-1:0]    divisor,
   output sitrd_pkg::div_result_type                result
);

   logic [sitrd_pkg::VALUE_WIDTH-1:0]   work_ff;
   logic [sitrd_pkg::VALUE_WIDTH-1:0]   work_in;
   logic [sitrd_pkg::DIGIT_WIDTH-1:0]   rem_ff;
   logic [sitrd_pkg::DIGIT_WIDTH-1:0]   rem_in;
   logic [sitrd_pkg::DIV_CNT_WIDTH-1:0] cnt_ff;
   logic [sitrd_pkg::DIV_CNT_WIDTH-1:0] cnt_in;
   logic                                busy_ff;
   logic                                busy_in;
   logic                                done_ff;
   logic                                done_in;
   logic [sitrd_pkg::VALUE_WIDTH-1:0]   step_work;
   logic [sitrd_pkg::DIGIT_WIDTH-1:0]   step_rem;
   logic [sitrd_pkg::BASE_WIDTH-1:0]    trial;

   // The work register shifts dividend bits out at the top and quotient bits
   // in at the bottom; after all steps it holds the quotient.
   always_comb begin
      step_work = start ? dividend : work_ff;
      step_rem  = start ? '0 : rem_ff;
      trial     = '0;
      for (int s = 0; s < sitrd_pkg::STEPS_PER_CYCLE; s++) begin
         trial = {step_rem, step_work[sitrd_pkg::VALUE_WIDTH-1]};
         if (trial >= divisor) begin
            trial     = trial - divisor;
            step_work = {step_work[sitrd_pkg::VALUE_WIDTH-2:0], 1'b1};
         end else begin
            step_work = {step_work[sitrd_pkg::VALUE_WIDTH-2:0], 1'b0};
         end
         step_rem = trial[sitrd_pkg::DIGIT_WIDTH-1:0];
      end
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = step_work;
         rem_in  = step_rem;
         cnt_in  = sitrd_pkg::DIV_CNT_WIDTH'(1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = step_work;
         rem_in  = step_rem;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == sitrd_pkg::DIV_CNT_WIDTH'(sitrd_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_integer_to_radix_digits_unit.sv =====
// Signed integer to radix digits: a signed 32-bit value as text in a configured
// radix and symbol table. Depends on sitrd_pkg, sitrd_csr and sitrd_div.
// The divider makes one pass per digit; the digits are stacked, then sent most
// significant first; an invalid table answers in the next cycle. One item at a
// time: a new value is taken only when idle with no result held, and result
// stalls hold the output. Sync reset clears control and count.
`default_nettype none

module signed_integer_to_radix_digits_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [sitrd_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      [7:0]                             rsp_out_char,
   output logic                                        rsp_char_valid,
   output logic                                        rsp_last_char,
   output logic      [31:0]                            rsp_running_count,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [sitrd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                        csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   sitrd_pkg::cfg_type         cfg;
   sitrd_pkg::div_result_type  div_res;

   state_type                           state_ff;
   state_type                           state_in;
   logic [sitrd_pkg::DEPTH_WIDTH-1:0]   depth_ff;
   logic [sitrd_pkg::DEPTH_WIDTH-1:0]   depth_in;
   logic [sitrd_pkg::DEPTH_WIDTH-1:0]   depth_dec;
   logic                                neg_ff;
   logic                                neg_in;
   logic [31:0]                         count_ff;
   logic [31:0]                         count_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [7:0]                          rsp_char_ff;
   logic [7:0]                          rsp_char_in;
   logic                                rsp_cvalid_ff;
   logic                                rsp_cvalid_in;
   logic                                rsp_last_ff;
   logic                                rsp_last_in;
   logic [31:0]                         rsp_count_ff;
   logic [31:0]                         rsp_count_in;
   logic [sitrd_pkg::DIGIT_WIDTH-1:0]   digit_stack [sitrd_pkg::MAX_DIGITS];
   logic                                push;
   logic                                accept;
   logic                                slot_free;
   logic                                div_start;
   logic [sitrd_pkg::VALUE_WIDTH-1:0]   magnitude;
   logic [sitrd_pkg::VALUE_WIDTH-1:0]   div_dividend;
   logic [sitrd_pkg::DIGIT_WIDTH-1:0]   top_digit;

   sitrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sitrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cfg.base_size),
      .result   (div_res)
   );

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   // Negation in 32 unsigned bits keeps the most negative value exact.
   assign magnitude  = req_value[sitrd_pkg::VALUE_WIDTH-1] ? (32'd0 - 32'(req_value))
                                                            : 32'(req_value);
   assign div_dividend = (state_ff == ST_IDLE) ? magnitude : div_res.quotient;
   assign div_start  = (accept && cfg.valid) ||
                       (state_ff == ST_DIVIDE && div_res.done && div_res.quotient != '0);
   assign push       = (state_ff == ST_DIVIDE) && div_res.done;
   assign depth_dec  = depth_ff - 1'b1;
   assign top_digit  = digit_stack[depth_dec[sitrd_pkg::DEPTH_WIDTH-2:0]];

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      neg_in        = neg_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = req_value[sitrd_pkg::VALUE_WIDTH-1];
               depth_in = '0;
               if (cfg.valid) begin
                  state_in = ST_DIVIDE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = sitrd_pkg::CHAR_NUL;
                  rsp_cvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_count_in  = count_ff;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               depth_in = depth_ff + 1'b1;
               if (div_res.quotient == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               count_in      = count_ff + 32'd1;
               rsp_valid_in  = 1'b1;
               rsp_char_in   = sitrd_pkg::CHAR_MINUS;
               rsp_cvalid_in = 1'b1;
               rsp_last_in   = 1'b0;
               rsp_count_in  = count_ff + 32'd1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               depth_in      = depth_dec;
               count_in      = count_ff + 32'd1;
               rsp_valid_in  = 1'b1;
               rsp_char_in   = cfg.symbols[top_digit];
               rsp_cvalid_in = 1'b1;
               rsp_last_in   = (depth_dec == '0);
               rsp_count_in  = count_ff + 32'd1;
               if (depth_dec == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      if (push) begin
         digit_stack[depth_ff[sitrd_pkg::DEPTH_WIDTH-2:0]] <= div_res.remainder;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_char_valid    = rsp_cvalid_ff;
   assign rsp_last_char     = rsp_last_ff;
   assign rsp_running_count = rsp_count_ff;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_last_char)
      else $error("empty result without last flag");

   a_idle_stack_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> depth_ff == '0)
      else $error("digit stack not drained when idle");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= sitrd_pkg::DEPTH_WIDTH'(sitrd_pkg::MAX_DIGITS))
      else $error("digit stack overflow");

endmodule

`default_nettype wire

// ===== dv/sitrd_text_checker.sv =====
// Checker for the signed integer to radix digits unit: follows register writes,
// predicts the characters of every accepted value and compares each result.
// Depends on sitrd_pkg for widths, register indexes and character codes.
module sitrd_text_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic [sitrd_pkg::VALUE_WIDTH-1:0]    req_value,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic [7:0]                           rsp_out_char,
   input  wire logic                                 rsp_char_valid,
   input  wire logic                                 rsp_last_char,
   input  wire logic [31:0]                          rsp_running_count,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [sitrd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [sitrd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  wire logic                                 csr_pready,
   output int                                        fail_count,
   output int                                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        char_valid;
      logic        last_char;
      logic [31:0] running_count;
   } text_char_type;

   text_char_type expected_chars[$];
   logic [4:0]    radix;
   logic [63:0]   sym_low;
   logic [63:0]   sym_high;
   logic [31:0]   chars_emitted;
   int            errors;

   function automatic logic [7:0] symbol_of(input int k);
      if (k < 8) begin
         return sym_low[8*k +: 8];
      end
      return sym_high[8*(k-8) +: 8];
   endfunction

   function automatic bit table_ok();
      int         i;
      int         j;
      logic [7:0] s;
      if (radix < sitrd_pkg::MIN_BASE || radix > sitrd_pkg::MAX_SYMBOLS) begin
         return 1'b0;
      end
      for (i = 0; i < radix; i++) begin
         s = symbol_of(i);
         if (s == sitrd_pkg::CHAR_MINUS || s == sitrd_pkg::CHAR_PLUS ||
             s == sitrd_pkg::CHAR_NUL) begin
            return 1'b0;
         end
         for (j = i + 1; j < radix; j++) begin
            if (symbol_of(j) == s) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Digits come out of the division least significant first and are
   // emitted in reverse, after the sign.
   task automatic predict_text(input logic [31:0] raw);
      logic [31:0]                       mag;
      logic [31:0]                       divisor;
      logic [sitrd_pkg::DIGIT_WIDTH-1:0] digits[sitrd_pkg::MAX_DIGITS];
      int                                depth;
      bit                                neg;
      neg     = raw[31];
      mag     = neg ? 32'(0 - raw) : raw;
      divisor = 32'(radix);
      depth   = 0;
      if (!table_ok()) begin
         expected_chars.push_back('{sitrd_pkg::CHAR_NUL, 1'b0, 1'b1, chars_emitted});
         return;
      end
      do begin
         if (depth < sitrd_pkg::MAX_DIGITS) begin
            digits[depth] = sitrd_pkg::DIGIT_WIDTH'(mag % divisor);
            depth++;
         end
         mag = mag / divisor;
      end while (mag != 0);
      if (neg) begin
         chars_emitted++;
         expected_chars.push_back('{sitrd_pkg::CHAR_MINUS, 1'b1, 1'b0, chars_emitted});
      end
      while (depth > 0) begin
         depth--;
         chars_emitted++;
         expected_chars.push_back('{symbol_of(digits[depth]), 1'b1, depth == 0,
                                    chars_emitted});
      end
   endtask

   always @(posedge clock) begin : monitor
      text_char_type want;
      if (reset) begin
         radix         = '0;
         sym_low       = '0;
         sym_high      = '0;
         chars_emitted = '0;
         expected_chars.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr >> 3)
               sitrd_pkg::REG_BASE_SIZE:    radix    = csr_pwdata[4:0];
               sitrd_pkg::REG_SYMBOLS_LOW:  sym_low  = csr_pwdata;
               sitrd_pkg::REG_SYMBOLS_HIGH: sym_high = csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_text(req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected transfer: out_char %0h running_count %0d",
                      rsp_out_char, rsp_running_count);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.out_char) begin
                  $error("out_char: expected %0h, got %0h", want.out_char, rsp_out_char);
                  errors++;
               end
               if (rsp_char_valid !== want.char_valid) begin
                  $error("char_valid: expected %0b, got %0b",
                         want.char_valid, rsp_char_valid);
                  errors++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %0b, got %0b", want.last_char, rsp_last_char);
                  errors++;
               end
               if (rsp_running_count !== want.running_count) begin
                  $error("running_count: expected %0d, got %0d",
                         want.running_count, rsp_running_count);
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_chars.size();
   end

   initial begin
      errors     = 0;
      fail_count = 0;
      pending    = 0;
   end

endmodule

// ===== dv/tb_signed_integer_to_radix_digits_unit.sv =====
// Testbench top for the signed integer to radix digits unit: clock, reset,
// register writes, value stimulus with random idling, watchdog and verdict.
// Depends on sitrd_pkg, the unit itself and sitrd_text_checker.
module tb_signed_integer_to_radix_digits_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_UNUSED     = 2'd3;
   localparam int         RANDOM_ITEMS   = 105;
   localparam int         QUIET_AFTER    = 85;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 200;

   localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] DEC_HIGH = 64'h0000_0000_0000_3938;
   localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [sitrd_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [7:0]                             rsp_out_char;
   logic                                   rsp_char_valid;
   logic                                   rsp_last_char;
   logic [31:0]                            rsp_running_count;
   logic                                   csr_psel = 1'b0;
   logic                                   csr_penable = 1'b0;
   logic                                   csr_pwrite = 1'b0;
   logic [sitrd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr = '0;
   logic [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata = '0;
   logic [sitrd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata;
   logic                                   csr_pready;
   logic                                   quiet = 1'b0;
   int                                     fail_count;
   int                                     pending;
   int                                     idle_cycles = 0;

   always #2 clock = ~clock;

   signed_integer_to_radix_digits_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_last_char     (rsp_last_char),
      .rsp_running_count (rsp_running_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   sitrd_text_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_last_char     (rsp_last_char),
      .rsp_running_count (rsp_running_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // The watchdog restarts on any transfer or register write.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stalls between ready stretches.
   initial begin : rsp_side
      forever begin
         if (quiet || reset) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_table(input logic [4:0] radix, input logic [63:0] low,
                            input logic [63:0] high);
      write_reg(sitrd_pkg::REG_BASE_SIZE, 64'(radix));
      write_reg(sitrd_pkg::REG_SYMBOLS_LOW, low);
      write_reg(sitrd_pkg::REG_SYMBOLS_HIGH, high);
   endtask

   // Holds off until every expected character has been seen. The checker's
   // count is registered, so it is trusted only after it has been updated.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_value(input logic [31:0] v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 40));
         1: return 32'(0 - $urandom_range(1, 40));
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'h8000_0001;
               default: return 32'h0;
            endcase
         end
         3: return 32'($urandom_range(0, 2000)) - 32'd1000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed tables with distinct legal symbols; some are broken
   // by one forbidden or repeated symbol, some are raw noise.
   task automatic random_config();
      logic [15:0][7:0] tab;
      logic [7:0]       b;
      logic [4:0]       radix;
      bit               clash;
      int               k;
      int               m;
      int               slot;
      int               kind;
      kind = $urandom_range(0, 9);
      for (k = 0; k < 16; k++) begin
         do begin
            b     = 8'($urandom_range(1, 255));
            clash = (b == sitrd_pkg::CHAR_PLUS) || (b == sitrd_pkg::CHAR_MINUS);
            for (m = 0; m < k; m++) begin
               if (tab[m] == b) clash = 1'b1;
            end
         end while (clash);
         tab[k] = b;
      end
      case ($urandom_range(0, 3))
         0: radix = 5'd2;
         1: radix = 5'd16;
         default: radix = 5'($urandom_range(2, 16));
      endcase
      if (kind == 0) begin
         radix = 5'($urandom_range(0, 31));
         tab   = {$urandom, $urandom, $urandom, $urandom};
      end else if (kind == 1) begin
         slot = $urandom_range(0, radix - 1);
         case ($urandom_range(0, 3))
            0: tab[slot] = sitrd_pkg::CHAR_PLUS;
            1: tab[slot] = sitrd_pkg::CHAR_MINUS;
            2: tab[slot] = sitrd_pkg::CHAR_NUL;
            default: tab[slot] = tab[(slot + 1) % radix];
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         write_reg(REG_UNUSED, {$urandom, $urandom});
      end
      set_table(radix, tab[7:0], tab[15:8]);
   endtask

   initial begin : stimulus
      int random_sent;
      int burst;
      random_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers still at their reset values: the table is invalid.
      send_value(32'd5);
      send_value(32'hFFFF_FFFF);

      settle();
      set_table(5'd10, DEC_LOW, DEC_HIGH);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd10);
      send_value(32'hFFFF_FFF6);

      // Binary gives the longest text, the most negative value most of all.
      settle();
      set_table(5'd2, DEC_LOW, DEC_HIGH);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);

      settle();
      set_table(5'd16, DEC_LOW, HEX_HIGH);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hDEAD_BEEF);
      send_value(32'd15);

      // Broken tables: radix out of range, forbidden and repeated symbols.
      settle();
      set_table(5'd1, DEC_LOW, DEC_HIGH);
      send_value(32'd7);
      settle();
      set_table(5'd17, DEC_LOW, HEX_HIGH);
      send_value(32'd7);
      settle();
      set_table(5'd31, DEC_LOW, HEX_HIGH);
      send_value(32'hFFFF_FFF9);
      settle();
      set_table(5'd10, 64'h3736_3534_2B32_3130, DEC_HIGH);
      send_value(32'd12);
      settle();
      set_table(5'd10, DEC_LOW, 64'h0000_0000_0000_2D38);
      send_value(32'd12);
      settle();
      set_table(5'd16, DEC_LOW, DEC_HIGH);
      send_value(32'd12);
      settle();
      set_table(5'd10, 64'h3736_3134_3332_3130, DEC_HIGH);
      send_value(32'd12);

      // A write past the last register must leave the table alone.
      settle();
      set_table(5'd16, DEC_LOW, HEX_HIGH);
      write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_value(32'h0123_4567);

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         if (random_sent >= QUIET_AFTER) quiet <= 1'b1;
         random_config();
         burst = $urandom_range(6, 18);
         repeat (burst) begin
            send_value(random_value());
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      quiet     <= 1'b1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
